// ===== rtl/nedist_pkg.sv =====
// Shared types and constants for the normalized edit distance block.
package nedist_pkg;

    localparam int IN_CHAR_W     = 16;
    localparam int OUT_LEN_W     = 7;
    localparam int SIM_W         = 16;
    localparam int SIM_FRAC_BITS = 15;
    localparam int DIV_STEPS     = SIM_FRAC_BITS;
    localparam int DIV_CNT_W     = $clog2(DIV_STEPS);

    typedef enum logic [1:0] {
        CMD_APPEND_FIRST  = 2'd0,
        CMD_APPEND_SECOND = 2'd1,
        CMD_COMPUTE       = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_ROW,
        S_CELL,
        S_QINT,
        S_DIV,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [1:0]           command;
        logic [IN_CHAR_W-1:0] character;
    } t_in_item;

    typedef struct packed {
        logic [OUT_LEN_W-1:0] distance;
        logic [OUT_LEN_W-1:0] longer_length;
        logic [SIM_W-1:0]     similarity;
        logic                 overflow;
    } t_out_item;

endpackage

// ===== rtl/normalized_edit_distance_top.sv =====
// Normalized edit distance: string loader, DP row walker and similarity divider.
//
// Append transactions (command 0 or 1) each store one character into the first or
// second string memory; characters past MAX_LEN are dropped and flag overflow. A
// compute transaction (command 2) walks the Levenshtein table one cell per cycle
// within a row, through a single cost-row memory (read one entry, write one entry
// each cycle), then runs a 15-step restoring division for the Q1.15 similarity.
// With either string empty the table walk and division are skipped. No new
// transaction is accepted until the result sits in the output register, which then
// waits for the consumer while loading resumes. Compute clears both strings and
// the overflow flag. Command 3 is accepted and ignored.
module normalized_edit_distance_top
    import nedist_pkg::*;
#(
    parameter int MAX_LEN   = 64,
    parameter int CHAR_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_in_item  i_data,
    output logic      o_ready,
    output logic      o_valid,
    output t_out_item o_data,
    input  logic      i_ready
);

    localparam int CW = (CHAR_BITS < IN_CHAR_W) ? CHAR_BITS : IN_CHAR_W;
    localparam int DW = $clog2(MAX_LEN + 1);
    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

    // control state
    t_state r_state, n_state;
    logic [DW-1:0] r_len1, n_len1;
    logic [DW-1:0] r_len2, n_len2;
    logic r_dropped, n_dropped;
    logic r_out_valid, n_out_valid;

    // datapath registers
    logic [DW-1:0] r_i, n_i;
    logic [DW-1:0] r_j, n_j;
    logic [DW-1:0] r_left, n_left;
    logic [DW-1:0] r_diag, n_diag;
    logic [DW-1:0] r_longer, n_longer;
    logic [DW-1:0] r_d, n_d;
    logic [DW:0] r_rem, n_rem;
    logic [SIM_W-1:0] r_q, n_q;
    logic [DIV_CNT_W-1:0] r_k, n_k;
    t_out_item r_out, n_out;

    // memories
    logic [CW-1:0] r_first_mem [MAX_LEN];
    logic [CW-1:0] r_second_mem [MAX_LEN];
    logic [DW-1:0] r_cost_mem [MAX_LEN];
    logic [CW-1:0] r_first_rd;
    logic [CW-1:0] r_second_rd;
    logic [DW-1:0] r_cost_rd;

    logic first_we, second_we, cost_we;
    logic first_re, row_re;
    logic [AW-1:0] first_waddr, second_waddr, cost_waddr;
    logic [AW-1:0] first_raddr, row_raddr;
    logic [DW-1:0] cost_wdata;
    logic [CW-1:0] in_char;

    logic in_fire, out_free;
    logic [DW-1:0] i_m1, j_m1, same;
    logic [DW:0] c_up, c_left, c_diag, c_min, rem2;
    logic [DW-1:0] cell_new;
    logic sub;

    assign o_ready  = (r_state == S_IDLE);
    assign o_valid  = r_out_valid;
    assign o_data   = r_out;
    assign in_fire  = i_valid && o_ready;
    assign out_free = !r_out_valid || i_ready;
    assign in_char  = i_data.character[CW-1:0];

    assign i_m1 = r_i - DW'(1);
    assign j_m1 = r_j - DW'(1);

    // one DP cell: min(above + 1, left + 1, diag + mismatch)
    assign sub    = (r_first_rd != r_second_rd);
    assign c_up   = {1'b0, r_cost_rd} + (DW+1)'(1);
    assign c_left = {1'b0, r_left} + (DW+1)'(1);
    assign c_diag = {1'b0, r_diag} + (DW+1)'(sub);
    always_comb begin
        c_min = (c_up < c_left) ? c_up : c_left;
        if (c_diag < c_min) begin
            c_min = c_diag;
        end
    end
    assign cell_new = c_min[DW-1:0];

    assign same = r_longer - r_d;
    assign rem2 = {r_rem[DW-1:0], 1'b0};

    always_comb begin
        n_state     = r_state;
        n_len1      = r_len1;
        n_len2      = r_len2;
        n_dropped   = r_dropped;
        n_out_valid = r_out_valid;
        n_i         = r_i;
        n_j         = r_j;
        n_left      = r_left;
        n_diag      = r_diag;
        n_longer    = r_longer;
        n_d         = r_d;
        n_rem       = r_rem;
        n_q         = r_q;
        n_k         = r_k;
        n_out       = r_out;

        first_we     = 1'b0;
        second_we    = 1'b0;
        cost_we      = 1'b0;
        first_re     = 1'b0;
        row_re       = 1'b0;
        first_waddr  = r_len1[AW-1:0];
        second_waddr = r_len2[AW-1:0];
        cost_waddr   = j_m1[AW-1:0];
        cost_wdata   = r_j;
        first_raddr  = i_m1[AW-1:0];
        row_raddr    = '0;

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    case (i_data.command)
                        CMD_APPEND_FIRST: begin
                            if (r_len1 < DW'(MAX_LEN)) begin
                                first_we = 1'b1;
                                n_len1   = r_len1 + DW'(1);
                            end else begin
                                n_dropped = 1'b1;
                            end
                        end
                        CMD_APPEND_SECOND: begin
                            if (r_len2 < DW'(MAX_LEN)) begin
                                second_we = 1'b1;
                                n_len2    = r_len2 + DW'(1);
                            end else begin
                                n_dropped = 1'b1;
                            end
                        end
                        CMD_COMPUTE: begin
                            n_longer = (r_len1 > r_len2) ? r_len1 : r_len2;
                            if (r_len1 == '0 || r_len2 == '0) begin
                                n_d     = (r_len1 == '0) ? r_len2 : r_len1;
                                n_q     = '0;
                                n_state = S_OUT;
                            end else begin
                                n_j     = DW'(1);
                                n_state = S_INIT;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_INIT: begin
                // cost row starts as 1..m
                cost_we = 1'b1;
                if (r_j == r_len2) begin
                    n_i     = DW'(1);
                    n_state = S_ROW;
                end else begin
                    n_j = r_j + DW'(1);
                end
            end
            S_ROW: begin
                // column 0 of row i is i, of row i-1 is i-1
                first_re = 1'b1;
                row_re   = 1'b1;
                n_j      = DW'(1);
                n_left   = r_i;
                n_diag   = i_m1;
                n_state  = S_CELL;
            end
            S_CELL: begin
                cost_we    = 1'b1;
                cost_wdata = cell_new;
                n_left     = cell_new;
                n_diag     = r_cost_rd;
                if (r_j == r_len2) begin
                    if (r_i == r_len1) begin
                        n_d     = cell_new;
                        n_state = S_QINT;
                    end else begin
                        n_i     = r_i + DW'(1);
                        n_state = S_ROW;
                    end
                end else begin
                    n_j       = r_j + DW'(1);
                    row_re    = 1'b1;
                    row_raddr = r_j[AW-1:0];
                end
            end
            S_QINT: begin
                // integer bit of the quotient: only when distance is zero
                if (same == r_longer) begin
                    n_q   = SIM_W'(1);
                    n_rem = '0;
                end else begin
                    n_q   = '0;
                    n_rem = {1'b0, same};
                end
                n_k     = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                if (rem2 >= {1'b0, r_longer}) begin
                    n_rem = rem2 - {1'b0, r_longer};
                    n_q   = {r_q[SIM_W-2:0], 1'b1};
                end else begin
                    n_rem = rem2;
                    n_q   = {r_q[SIM_W-2:0], 1'b0};
                end
                if (r_k == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_OUT;
                end else begin
                    n_k = r_k + DIV_CNT_W'(1);
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_out_valid         = 1'b1;
                    n_out.distance      = OUT_LEN_W'(r_d);
                    n_out.longer_length = OUT_LEN_W'(r_longer);
                    n_out.similarity    = r_q;
                    n_out.overflow      = r_dropped;
                    n_len1              = '0;
                    n_len2              = '0;
                    n_dropped           = 1'b0;
                    n_state             = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len1      <= '0;
            r_len2      <= '0;
            r_dropped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_len1      <= n_len1;
            r_len2      <= n_len2;
            r_dropped   <= n_dropped;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i      <= n_i;
        r_j      <= n_j;
        r_left   <= n_left;
        r_diag   <= n_diag;
        r_longer <= n_longer;
        r_d      <= n_d;
        r_rem    <= n_rem;
        r_q      <= n_q;
        r_k      <= n_k;
        r_out    <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (first_we) begin
            r_first_mem[first_waddr] <= in_char;
        end
        if (first_re) begin
            r_first_rd <= r_first_mem[first_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (second_we) begin
            r_second_mem[second_waddr] <= in_char;
        end
        if (row_re) begin
            r_second_rd <= r_second_mem[row_raddr];
        end
    end

    // write of column j and read of column j+1 never collide; the row-start
    // cycle separates the last write of a row from the first read of the next
    always_ff @(posedge i_clk) begin
        if (cost_we) begin
            r_cost_mem[cost_waddr] <= cost_wdata;
        end
        if (row_re) begin
            r_cost_rd <= r_cost_mem[row_raddr];
        end
    end

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_len1 <= DW'(MAX_LEN)) && (r_len2 <= DW'(MAX_LEN)))
        else $error("string length beyond capacity");

    a_cell_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CELL) |->
            (r_j != '0) && (r_j <= r_len2) && (r_i != '0) && (r_i <= r_len1))
        else $error("DP cell index out of range");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < {1'b0, r_longer}))
        else $error("divider remainder not below divisor");

    a_result_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) && out_free |=>
            o_valid && (r_state == S_IDLE) && (r_len1 == '0) && (r_len2 == '0) && !r_dropped)
        else $error("result transaction did not clear the strings");

endmodule
